// File: rtl/sdiv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdiv_pkg
// Shared constants and types for the signed restoring divider pipeline.
// ----------------------------------------------------------------------------
package sdiv_pkg;

   // Default operand width
   localparam int SDIV_DATA_WIDTH = 32;

   // Per-item flags carried down the pipeline next to the data
   typedef struct packed {
      logic negate;    // operand signs differ, negate the quotient
      logic div_zero;  // divisor is zero, force the largest positive value
   } sdiv_flags_type;

endpackage : sdiv_pkg
`default_nettype wire

// File: rtl/sdiv_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdiv_prep
// Entry stage: takes operand magnitudes, result sign and zero-divisor flag.
// ----------------------------------------------------------------------------
module sdiv_prep
   import sdiv_pkg::*;
#(
   parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // upstream
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [DATA_WIDTH-1:0] in_num,
   input  wire logic [DATA_WIDTH-1:0] in_den,
   // downstream
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [DATA_WIDTH-1:0]      out_nq,
   output logic [DATA_WIDTH-1:0]      out_rem,
   output logic [DATA_WIDTH-1:0]      out_dmag,
   output sdiv_flags_type             out_flags
);

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] nmag_ff, nmag_in;
   logic [DATA_WIDTH-1:0] dmag_ff, dmag_in;
   sdiv_flags_type        flags_ff, flags_in;
   logic                  load;

   // Stage takes a new item when empty or when its item moves on
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;

   // Magnitudes; the most negative value maps to 2^(W-1) unsigned
   always_comb begin
      nmag_in           = in_num[DATA_WIDTH-1] ? (~in_num + 1'b1) : in_num;
      dmag_in           = in_den[DATA_WIDTH-1] ? (~in_den + 1'b1) : in_den;
      flags_in.negate   = in_num[DATA_WIDTH-1] ^ in_den[DATA_WIDTH-1];
      flags_in.div_zero = (in_den == '0);
      valid_in          = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         nmag_ff  <= nmag_in;
         dmag_ff  <= dmag_in;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_nq    = nmag_ff;
   assign out_rem   = '0;
   assign out_dmag  = dmag_ff;
   assign out_flags = flags_ff;

endmodule : sdiv_prep
`default_nettype wire

// File: rtl/sdiv_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdiv_step
// One restoring shift-subtract step with its pipeline register.
// ----------------------------------------------------------------------------
module sdiv_step
   import sdiv_pkg::*;
#(
   parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // upstream
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [DATA_WIDTH-1:0] in_nq,
   input  wire logic [DATA_WIDTH-1:0] in_rem,
   input  wire logic [DATA_WIDTH-1:0] in_dmag,
   input  wire sdiv_flags_type        in_flags,
   // downstream
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [DATA_WIDTH-1:0]      out_nq,
   output logic [DATA_WIDTH-1:0]      out_rem,
   output logic [DATA_WIDTH-1:0]      out_dmag,
   output sdiv_flags_type             out_flags
);

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] nq_ff, nq_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dmag_ff;
   sdiv_flags_type        flags_ff;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;
   logic                  qbit;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;

   // nq holds the unused dividend bits on top and quotient bits below.
   // Shift the next dividend bit into the partial remainder and try
   // subtracting the divisor; no borrow means the quotient bit is one.
   always_comb begin
      trial    = {in_rem, in_nq[DATA_WIDTH-1]};
      diff     = trial - {1'b0, in_dmag};
      qbit     = !diff[DATA_WIDTH];
      rem_in   = qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
      nq_in    = {in_nq[DATA_WIDTH-2:0], qbit};
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         nq_ff    <= nq_in;
         rem_ff   <= rem_in;
         dmag_ff  <= in_dmag;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_nq    = nq_ff;
   assign out_rem   = rem_ff;
   assign out_dmag  = dmag_ff;
   assign out_flags = flags_ff;

endmodule : sdiv_step
`default_nettype wire

// File: rtl/sdiv_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdiv_post
// Output stage: applies the result sign or the zero-divisor value.
// ----------------------------------------------------------------------------
module sdiv_post
   import sdiv_pkg::*;
#(
   parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // upstream
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [DATA_WIDTH-1:0] in_quo,
   input  wire sdiv_flags_type        in_flags,
   // result channel
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [DATA_WIDTH-1:0]      out_quo
);

   localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_ready && in_valid;

   // Zero divisor wins; otherwise negate on differing signs (wraps)
   always_comb begin
      priority if (in_flags.div_zero) begin
         quo_in = MaxPos;
      end else if (in_flags.negate) begin
         quo_in = ~in_quo + 1'b1;
      end else begin
         quo_in = in_quo;
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_quo   = quo_ff;

endmodule : sdiv_post
`default_nettype wire

// File: rtl/signed_restoring_divider_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_restoring_divider_top
// Pipelined signed divider, quotient truncated toward zero.
//
//   channel   ports                                         direction
//   req       req_valid, req_stall, req_numerator,
//             req_denominator                               in
//   rsp       rsp_valid, rsp_stall, rsp_quotient_out        out
//
// Accepts one item per cycle unless backed up by rsp_stall; the stages are
// one entry stage, one stage per quotient bit and one output stage.
// Synchronous active-high reset empties the pipeline; no data is cleared.
// Each stage holds its item while the stage after it is full and stalled,
// so bubbles close up under rsp_stall. req_stall follows that chain.
// ----------------------------------------------------------------------------
module signed_restoring_divider_top
   import sdiv_pkg::*;
#(
   parameter int DATA_WIDTH = SDIV_DATA_WIDTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [DATA_WIDTH-1:0] req_numerator,
   input  wire logic signed [DATA_WIDTH-1:0] req_denominator,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0]      rsp_quotient_out
);

   // Inter-stage links: index 0 is the entry stage output
   logic                  stg_valid [0:DATA_WIDTH];
   logic                  stg_ready [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] stg_nq    [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] stg_rem   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] stg_dmag  [0:DATA_WIDTH];
   sdiv_flags_type        stg_flags [0:DATA_WIDTH];
   logic                  prep_ready;
   logic [DATA_WIDTH-1:0] quo;

   assign req_stall = !prep_ready;

   // Entry stage
   sdiv_prep #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (prep_ready),
      .in_num    ($unsigned(req_numerator)),
      .in_den    ($unsigned(req_denominator)),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_nq    (stg_nq[0]),
      .out_rem   (stg_rem[0]),
      .out_dmag  (stg_dmag[0]),
      .out_flags (stg_flags[0])
   );

   // One stage per quotient bit, most significant first
   for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
      sdiv_step #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_nq     (stg_nq[k]),
         .in_rem    (stg_rem[k]),
         .in_dmag   (stg_dmag[k]),
         .in_flags  (stg_flags[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_nq    (stg_nq[k+1]),
         .out_rem   (stg_rem[k+1]),
         .out_dmag  (stg_dmag[k+1]),
         .out_flags (stg_flags[k+1])
      );
   end

   // Sign and zero-divisor handling, result register
   sdiv_post #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[DATA_WIDTH]),
      .in_ready  (stg_ready[DATA_WIDTH]),
      .in_quo    (stg_nq[DATA_WIDTH]),
      .in_flags  (stg_flags[DATA_WIDTH]),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_quo   (quo)
   );

   assign rsp_quotient_out = $signed(quo);

endmodule : signed_restoring_divider_top
`default_nettype wire

// File: tb/tb_signed_restoring_divider_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_restoring_divider_top
// Self-checking bench for the pipelined signed divider. Every accepted item
// is predicted with a bit-serial restoring division and queued. Results are
// compared in order against that queue. Both channels idle at random, and
// the receiver holds off once for long enough to back up the pipeline.
// ----------------------------------------------------------------------------

// Keeps the expected quotients in acceptance order and checks results
class quotient_scoreboard;
   localparam int QW         = sdiv_pkg::SDIV_DATA_WIDTH;
   localparam int MAX_REPORT = 10;

   typedef logic [QW-1:0] word_type;
   typedef struct {
      word_type num;
      word_type den;
      word_type quo;
   } division_type;

   division_type pending_divisions[$];
   int           failures;

   function new();
      failures = 0;
   endfunction

   // Restoring shift-subtract division on magnitudes, sign fixed at the end
   function word_type predict_quotient(word_type num, word_type den);
      word_type nmag;
      word_type dmag;
      word_type rem;
      word_type quo;
      logic     carry;
      if (den == '0) begin
         return {1'b0, {(QW-1){1'b1}}};
      end
      nmag = num[QW-1] ? word_type'(-num) : num;
      dmag = den[QW-1] ? word_type'(-den) : den;
      rem  = '0;
      quo  = '0;
      for (int i = QW - 1; i >= 0; i--) begin
         carry = rem[QW-1];
         rem   = {rem[QW-2:0], nmag[i]};
         if (carry || rem >= dmag) begin
            rem    = rem - dmag;
            quo[i] = 1'b1;
         end
      end
      if (num[QW-1] ^ den[QW-1]) begin
         quo = -quo;
      end
      return quo;
   endfunction

   function void note_division(word_type num, word_type den);
      division_type d;
      d.num = num;
      d.den = den;
      d.quo = predict_quotient(num, den);
      pending_divisions.push_back(d);
   endfunction

   function void check_quotient(word_type actual);
      division_type d;
      if (pending_divisions.size() == 0) begin
         failures++;
         if (failures <= MAX_REPORT) begin
            $display("unexpected result %0d with no item outstanding", $signed(actual));
         end
         return;
      end
      d = pending_divisions.pop_front();
      if (actual !== d.quo) begin
         failures++;
         if (failures <= MAX_REPORT) begin
            $display("quotient mismatch: %0d / %0d expected %0d (%h) got %0d (%h)",
                     $signed(d.num), $signed(d.den), $signed(d.quo), d.quo,
                     $signed(actual), actual);
         end
      end
   endfunction
endclass

module tb_signed_restoring_divider_top;
   import sdiv_pkg::*;

   localparam int DW             = SDIV_DATA_WIDTH;
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_BLOCKS  = 14;
   localparam int BLOCK_ITEMS    = 50;
   localparam int HOLD_OFF       = 160;
   localparam int HOLD_OFF_AFTER = 60;
   localparam int DRAIN_CYCLES   = DW + 8;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef logic [DW-1:0] word_type;

   localparam word_type MOST_NEG = {1'b1, {(DW-1){1'b0}}};
   localparam word_type MOST_POS = {1'b0, {(DW-1){1'b1}}};
   localparam word_type MINUS_1  = {DW{1'b1}};
   localparam word_type PLUS_1   = word_type'(1);

   logic     clock = 1'b0;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   word_type req_numerator;
   word_type req_denominator;
   logic     rsp_valid;
   logic     rsp_stall;
   word_type rsp_quotient_out;

   quotient_scoreboard sb = new();

   int  divisions_accepted;
   int  idle_cycles;

   signed_restoring_divider_top #(.DATA_WIDTH(DW)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_numerator    (req_numerator),
      .req_denominator  (req_denominator),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_quotient_out (rsp_quotient_out)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Gap before an item: none unless bursty; then mostly none or short, a few long
   function automatic int unsigned pick_gap(bit bursty);
      int unsigned r;
      if (!bursty) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // Operand mix: full range, short magnitudes, tiny values, extremes, zero
   function automatic word_type pick_operand(int unsigned zero_pct);
      int unsigned r;
      word_type    v;
      r = $urandom_range(0, 99);
      if (r < zero_pct) begin
         v = '0;
      end else if (r < 45) begin
         v = word_type'($urandom);
      end else if (r < 75) begin
         v = word_type'($urandom) >> $urandom_range(0, DW - 1);
         if ($urandom_range(0, 1)) v = -v;
      end else if (r < 88) begin
         v = word_type'($urandom_range(1, 15));
         if ($urandom_range(0, 1)) v = -v;
      end else begin
         case ($urandom_range(0, 3))
            0:       v = MOST_NEG;
            1:       v = MOST_POS;
            2:       v = MINUS_1;
            default: v = PLUS_1;
         endcase
      end
      return v;
   endfunction

   // Offer one item after an optional gap and hold it until accepted
   task automatic send_division(input word_type num, input word_type den,
                                input int unsigned gap);
      if (gap != 0) begin
         req_valid       <= 1'b0;
         req_numerator   <= word_type'($urandom);
         req_denominator <= word_type'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_numerator   <= num;
      req_denominator <= den;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Accepted items on both channels, plus the idle watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            sb.note_division(req_numerator, req_denominator);
            divisions_accepted <= divisions_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_quotient(rsp_quotient_out);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver: quiet stretches, short stalls, rare long ones, one long hold-off
   initial begin
      bit          held_off;
      int unsigned run_len;
      int unsigned stall_len;
      int unsigned r;
      held_off = 1'b0;
      rsp_stall <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         if (!held_off && divisions_accepted >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < 20) begin
            run_len   = $urandom_range(20, 80);
            stall_len = 0;
         end else begin
            run_len   = $urandom_range(1, 8);
            stall_len = (r < 92) ? $urandom_range(1, 3) : $urandom_range(15, 40);
         end
         rsp_stall <= 1'b0;
         repeat (run_len) @(posedge clock);
         if (stall_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Stimulus and end of run
   initial begin
      bit bursty;
      divisions_accepted = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_numerator   <= '0;
      req_denominator <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero divisor, most negative operand, unit divisors, signs
      send_division('0, '0, pick_gap(1));
      send_division(word_type'(5), '0, pick_gap(1));
      send_division(word_type'(-5), '0, pick_gap(1));
      send_division(MOST_NEG, '0, pick_gap(1));
      send_division(MOST_POS, '0, pick_gap(1));
      send_division(MOST_NEG, MINUS_1, pick_gap(1));
      send_division(MOST_NEG, PLUS_1, pick_gap(1));
      send_division(MOST_POS, MINUS_1, pick_gap(1));
      send_division(MOST_POS, PLUS_1, pick_gap(1));
      send_division(MOST_NEG, MOST_NEG, pick_gap(1));
      send_division(MOST_POS, MOST_POS, pick_gap(1));
      send_division(MOST_NEG, MOST_POS, pick_gap(1));
      send_division(MOST_POS, MOST_NEG, pick_gap(1));
      send_division(word_type'(7), word_type'(2), pick_gap(1));
      send_division(word_type'(-7), word_type'(2), pick_gap(1));
      send_division(word_type'(7), word_type'(-2), pick_gap(1));
      send_division(word_type'(-7), word_type'(-2), pick_gap(1));
      send_division('0, word_type'(-3), pick_gap(1));
      send_division(PLUS_1, MOST_NEG, pick_gap(1));
      send_division(MINUS_1, MOST_NEG, pick_gap(1));
      send_division(word_type'(100), word_type'(7), pick_gap(1));
      send_division(word_type'(3), word_type'(100), pick_gap(1));
      send_division(MINUS_1, MINUS_1, pick_gap(1));

      // Random blocks, some back to back, the rest with random gaps
      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         bursty = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            send_division(pick_operand(5), pick_operand(5), pick_gap(bursty));
         end
      end
      req_valid <= 1'b0;

      // Drain, then let any stray result show up
      while (sb.pending_divisions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0 && sb.pending_divisions.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
